>>> hdl/stkr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the frame receiver.
package stkr_pkg;

  localparam int unsigned HEADER_PLUS_SUM = 6;   // start, sequence, length x2, token, checksum
  localparam int unsigned SEQ_POS         = 2;
  localparam int unsigned LENHI_POS       = 3;
  localparam int unsigned LEN_DONE_POS    = 4;
  localparam int unsigned TOKEN_DONE_POS  = 5;
  localparam int unsigned TOTAL_W         = 17;  // body length + header without wrap
  localparam int unsigned IDX_W           = 9;
  localparam logic [15:0] IDLE_MAX        = 16'hFFFF;

  localparam logic [7:0]  START_RESET     = 8'h1B;
  localparam logic [7:0]  TOKEN_RESET     = 8'h0E;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd200;

  typedef enum logic [1:0] {
    CFG_START   = 2'd0,
    CFG_TOKEN   = 2'd1,
    CFG_TIMEOUT = 2'd2,
    CFG_NONE    = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_TICK     = 3'd0,
    ST_TAKEN    = 3'd1,
    ST_GOOD     = 3'd2,
    ST_CKSUM    = 3'd3,
    ST_BADLEN   = 3'd4,
    ST_BADTOKEN = 3'd5,
    ST_OVERFLOW = 3'd6,
    ST_IGNORED  = 3'd7
  } status_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  echo_byte;
    logic [8:0]  byte_index;
    logic [7:0]  sequence_res;
    logic [15:0] body_length;
  } result_t;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  token_byte;
    logic [15:0] timeout_ticks;
  } cfg_t;

endpackage

>>> hdl/stkr_in_reg.sv
`timescale 1ns / 1ps
// Input register stage with stall back to the sender.
module stkr_in_reg import stkr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  // hold the registered item while the next stage cannot take it
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_item;
    end
  end

endmodule

>>> hdl/stkr_parser.sv
`timescale 1ns / 1ps
// Framing state and per-item decode of bytes and ticks.
module stkr_parser import stkr_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 512
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int unsigned PW = $clog2(FRAME_BYTES + 1);
  localparam int unsigned XW = (PW > IDX_W) ? PW : IDX_W;

  logic [PW-1:0]      frame_position, frame_position_next;
  logic [7:0]         running_xor, running_xor_next;
  logic [7:0]         frame_sequence, frame_sequence_next;
  logic [7:0]         length_high, length_high_next;
  logic [15:0]        body_len, body_len_next;
  logic [15:0]        idle_ticks, idle_ticks_next;

  logic [PW-1:0]      pos_eff;
  logic [PW-1:0]      pos_inc;
  logic [PW-1:0]      index;
  logic [XW-1:0]      index_x;
  logic [TOTAL_W-1:0] new_total;
  logic [TOTAL_W-1:0] cur_total;
  status_t            status;

  always_comb begin
    frame_position_next = frame_position;
    running_xor_next    = running_xor;
    frame_sequence_next = frame_sequence;
    length_high_next    = length_high;
    body_len_next       = body_len;
    idle_ticks_next     = idle_ticks;
    index               = '0;
    status              = ST_TICK;
    // a byte after the timeout starts over as if idle
    pos_eff   = (idle_ticks >= cfg.timeout_ticks) ? '0 : frame_position;
    pos_inc   = pos_eff + PW'(1);
    new_total = TOTAL_W'({length_high, item.data_byte}) + TOTAL_W'(HEADER_PLUS_SUM);
    cur_total = TOTAL_W'(body_len) + TOTAL_W'(HEADER_PLUS_SUM);

    if (item.cmd) begin
      if (idle_ticks != IDLE_MAX) begin
        idle_ticks_next = idle_ticks + 16'd1;
      end
    end else begin
      idle_ticks_next     = '0;
      frame_position_next = pos_eff;
      if (pos_eff == '0) begin
        if (item.data_byte == cfg.start_byte) begin
          frame_position_next = PW'(1);
          running_xor_next    = item.data_byte;
          frame_sequence_next = '0;
          length_high_next    = '0;
          body_len_next       = '0;
          status              = ST_TAKEN;
        end else begin
          status = ST_IGNORED;
        end
      end else if (pos_eff < PW'(FRAME_BYTES)) begin
        index               = pos_eff;
        frame_position_next = pos_inc;
        running_xor_next    = running_xor ^ item.data_byte;
        status              = ST_TAKEN;
        if (pos_inc == PW'(SEQ_POS)) begin
          frame_sequence_next = item.data_byte;
        end
        if (pos_inc == PW'(LENHI_POS)) begin
          length_high_next = item.data_byte;
        end
        priority if (pos_inc == PW'(LEN_DONE_POS)) begin
          body_len_next = {length_high, item.data_byte};
          if (new_total > TOTAL_W'(FRAME_BYTES)) begin
            frame_position_next = '0;
            status              = ST_BADLEN;
          end
        end else if (pos_inc == PW'(TOKEN_DONE_POS)) begin
          if (item.data_byte != cfg.token_byte) begin
            frame_position_next = '0;
            status              = ST_BADTOKEN;
          end
        end else if (pos_inc > PW'(LEN_DONE_POS) && TOTAL_W'(pos_inc) == cur_total) begin
          frame_position_next = '0;
          status = (running_xor_next == 8'd0) ? ST_GOOD : ST_CKSUM;
        end else begin
          status = ST_TAKEN;
        end
      end else begin
        index               = pos_eff;
        frame_position_next = '0;
        status              = ST_OVERFLOW;
      end
    end
  end

  assign index_x = XW'(index);

  always_comb begin
    if (item.cmd) begin
      result = '{status: ST_TICK, echo_byte: '0, byte_index: '0,
                 sequence_res: '0, body_length: '0};
    end else begin
      result = '{status: status, echo_byte: item.data_byte,
                 byte_index: index_x[IDX_W-1:0],
                 sequence_res: frame_sequence_next, body_length: body_len_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= '0;
      running_xor    <= '0;
      frame_sequence <= '0;
      length_high    <= '0;
      body_len       <= '0;
      idle_ticks     <= '0;
    end else if (fire) begin
      frame_position <= frame_position_next;
      running_xor    <= running_xor_next;
      frame_sequence <= frame_sequence_next;
      length_high    <= length_high_next;
      body_len       <= body_len_next;
      idle_ticks     <= idle_ticks_next;
    end
  end

endmodule

>>> hdl/stkr_out_reg.sv
`timescale 1ns / 1ps
// Result register toward the receiving side.
module stkr_out_reg import stkr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    res_valid,
  input  result_t res,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  // take a new result when empty or when the held one leaves this cycle
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

endmodule

>>> hdl/stk_frame_receiver.sv
`timescale 1ns / 1ps
// Top level of the frame receiver: config registers, input, parser and result stages.
// An item in the input register is decoded combinationally and captured into the result register
//   when the result stage can advance; the result register offers it on out_valid.
// Throughput: one item per cycle, bytes and ticks alike, while out_stall is low; a held result
//   stalls the input once the input register is full too (two items in flight).
// Reset: synchronous; clears framing state and valid flags, start 0x1B, token 0x0E, timeout 200.
module stk_frame_receiver import stkr_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  echo_byte,
  output logic [8:0]  byte_index,
  output logic [7:0]  sequence_res,
  output logic [15:0] body_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t res;
  result_t out_res;

  assign cfg_ready = 1'b1;
  assign in_item   = '{cmd: cmd, data_byte: data_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte    <= START_RESET;
      cfg.token_byte    <= TOKEN_RESET;
      cfg.timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_START:   cfg.start_byte    <= cfg_data[7:0];
        CFG_TOKEN:   cfg.token_byte    <= cfg_data[7:0];
        CFG_TIMEOUT: cfg.timeout_ticks <= cfg_data;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  stkr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  stkr_parser #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .fire   (item_valid && advance),
    .item   (item),
    .cfg    (cfg),
    .result (res)
  );

  stkr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (item_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign status       = out_res.status;
  assign echo_byte    = out_res.echo_byte;
  assign byte_index   = out_res.byte_index;
  assign sequence_res = out_res.sequence_res;
  assign body_length  = out_res.body_length;

endmodule
